/* rtl/cai_pkg.sv */
// Package for the checked 64-bit integer ALU.
// Holds command and status codes and the transaction payload structs.
// No dependencies.
`default_nettype none
package cai_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DivSteps = DataW;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_SUB  = 5'd1,
    CMD_MUL  = 5'd2,
    CMD_DIV  = 5'd3,
    CMD_EQ   = 5'd4,
    CMD_NE   = 5'd5,
    CMD_LT   = 5'd6,
    CMD_LE   = 5'd7,
    CMD_GT   = 5'd8,
    CMD_GE   = 5'd9,
    CMD_OR   = 5'd10,
    CMD_AND  = 5'd11,
    CMD_XOR  = 5'd12,
    CMD_LOR  = 5'd13,
    CMD_LAND = 5'd14,
    CMD_LOG2 = 5'd15,
    CMD_POW2 = 5'd16
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_t;

  // One divider/pipeline stage worth of in-flight state.
  typedef struct packed {
    logic        is_div;
    logic        is_mul;
    logic        neg;
    status_e     status;
    logic [63:0] value;
    logic [63:0] divisor;
    logic [63:0] rem;
    logic [63:0] dq;
  } stage_t;

endpackage
`default_nettype wire

/* rtl/checked_int64_alu.sv */
// Checked 64-bit integer ALU, top level.
// Depends on cai_pkg for codes, payload structs and the stage struct.
//
//   channel | signals                          | payload
//   input   | in_valid_i, in_stall_o, in_data_i   | in_t  (command, operands)
//   output  | out_valid_o, out_stall_i, out_data_o | out_t (value, status)
//
// One transaction per cycle while the output is not stalled.
// The divider computes one quotient bit per stage, 64 stages.
// Multiply: four 32x32 partial products, summed in msum_q, checked in stage 2.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module checked_int64_alu
  import cai_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam logic [63:0] Min64 = {1'b1, 63'd0};

  logic en;
  logic out_valid_q;
  out_t out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 0: decode and the combinational operations
  logic [63:0] a, b, ma, mb, sum, dif, log_v;
  logic        slt, sgt;
  stage_t      s0;

  assign a   = in_data_i.operand_a;
  assign b   = in_data_i.operand_b;
  assign ma  = a[63] ? (64'd0 - a) : a;
  assign mb  = b[63] ? (64'd0 - b) : b;
  assign sum = a + b;
  assign dif = a - b;
  assign slt = $signed(a) < $signed(b);
  assign sgt = $signed(b) < $signed(a);

  always_comb begin
    log_v = '1;
    for (int i = 0; i < 63; i++) begin
      if (ma[i]) log_v = 64'(i);
    end
    if (a == Min64) log_v = 64'd63;
  end

  always_comb begin
    s0         = '0;
    s0.status  = ST_OK;
    s0.divisor = mb;
    s0.dq      = ma;
    s0.neg     = a[63] ^ b[63];
    case (cmd_e'(in_data_i.command))
      CMD_ADD: begin
        s0.value = sum;
        if (((sum ^ a) & (sum ^ b)) >> 63 != 64'd0) s0.status = ST_OVF;
      end
      CMD_SUB: begin
        s0.value = dif;
        if (((a ^ b) & (dif ^ a)) >> 63 != 64'd0) s0.status = ST_OVF;
      end
      CMD_MUL: s0.is_mul = 1'b1;
      CMD_DIV: begin
        s0.is_div = 1'b1;
        if (b == 64'd0)                    s0.status = ST_DIV0;
        else if (a == Min64 && b == '1)    s0.status = ST_OVF;
      end
      CMD_EQ:   s0.value = {63'd0, a == b};
      CMD_NE:   s0.value = {63'd0, a != b};
      CMD_LT:   s0.value = {63'd0, slt};
      CMD_LE:   s0.value = {63'd0, !sgt};
      CMD_GT:   s0.value = {63'd0, sgt};
      CMD_GE:   s0.value = {63'd0, !slt};
      CMD_OR:   s0.value = a | b;
      CMD_AND:  s0.value = a & b;
      CMD_XOR:  s0.value = a ^ b;
      CMD_LOR:  s0.value = {63'd0, (a != 64'd0) || (b != 64'd0)};
      CMD_LAND: s0.value = {63'd0, (a != 64'd0) && (b != 64'd0)};
      CMD_LOG2: s0.value = log_v;
      CMD_POW2: begin
        if (a <= 64'd63) s0.value = 64'd1 << a[5:0];
        else             s0.status = ST_OVF;
      end
      default: s0.status = ST_OVF;
    endcase
  end

  // ---------------- divider pipeline, one quotient bit per stage
  stage_t st_q [DivSteps+1];
  stage_t st_d [DivSteps+1];
  logic   vld_q [DivSteps+1];

  logic [63:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic        mneg_q;
  logic [127:0] msum_q;
  logic         mneg2_q;
  logic [63:0]  mlo;
  logic         mbad;

  always_comb begin
    st_d[0] = s0;
    for (int k = 0; k < DivSteps; k++) begin
      logic [127:0] sh;
      logic [64:0]  trial;
      sh    = {st_q[k].rem, st_q[k].dq} << 1;
      trial = {1'b0, sh[127:64]} - {1'b0, st_q[k].divisor};
      st_d[k+1]     = st_q[k];
      st_d[k+1].rem = trial[64] ? sh[127:64] : trial[63:0];
      st_d[k+1].dq  = {sh[63:1], !trial[64]};
    end
    // merge the checked product into stage 2
    mlo  = msum_q[63:0];
    mbad = (msum_q[127:64] != 64'd0) ||
           (mneg2_q ? (mlo > Min64) : (mlo >= Min64));
    if (st_q[1].is_mul) begin
      st_d[2].status = mbad ? ST_OVF : ST_OK;
      st_d[2].value  = mneg2_q ? (64'd0 - mlo) : mlo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 0; k < DivSteps; k++) vld_q[k+1] <= vld_q[k];
      out_valid_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= DivSteps; k++) st_q[k] <= st_d[k];
      pp_ll_q <= 64'(ma[31:0])  * 64'(mb[31:0]);
      pp_lh_q <= 64'(ma[31:0])  * 64'(mb[63:32]);
      pp_hl_q <= 64'(ma[63:32]) * 64'(mb[31:0]);
      pp_hh_q <= 64'(ma[63:32]) * 64'(mb[63:32]);
      mneg_q  <= (a[63] ^ b[63]) && (ma != 64'd0) && (mb != 64'd0);
      msum_q  <= {64'd0, pp_ll_q} + {32'd0, pp_lh_q, 32'd0} +
                 {32'd0, pp_hl_q, 32'd0} + {pp_hh_q, 64'd0};
      mneg2_q <= mneg_q;
      // final select: zero on error, signed quotient for divide, else stage value
      if (st_q[DivSteps].status != ST_OK) begin
        out_q.value <= '0;
      end else if (st_q[DivSteps].is_div) begin
        out_q.value <= st_q[DivSteps].neg ? (64'd0 - st_q[DivSteps].dq)
                                          : st_q[DivSteps].dq;
      end else begin
        out_q.value <= st_q[DivSteps].value;
      end
      out_q.status <= st_q[DivSteps].status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* tb/sv/alu_checker.sv */
// Checker for the checked 64-bit integer ALU.
// Watches both channels, predicts value and status per transaction, compares in order.
// Depends on cai_pkg.
module alu_checker
  import cai_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o,
  output int   results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;

  out_t alu_results_q[$];

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic out_t compute_alu(in_t t);
    logic [63:0]  a, b, v, q;
    logic [127:0] p;
    logic signed [127:0] sp;
    status_e      st;
    a = t.operand_a;
    b = t.operand_b;
    v = '0;
    st = ST_OK;
    case (t.command)
      CMD_ADD: begin
        v = a + b;
        if ((v[63] ^ a[63]) && (v[63] ^ b[63])) st = ST_OVF;
      end
      CMD_SUB: begin
        v = a - b;
        if ((a[63] ^ b[63]) && (v[63] ^ a[63])) st = ST_OVF;
      end
      CMD_MUL: begin
        sp = $signed(t.operand_a) * $signed(t.operand_b);
        p = sp;
        // fits when the top 65 bits are all equal
        if (p[127:63] != {65{p[63]}}) st = ST_OVF;
        else v = p[63:0];
      end
      CMD_DIV: begin
        if (b == 0) st = ST_DIV0;
        else if (a == MinVal && b == '1) st = ST_OVF;
        else begin
          q = abs64(a) / abs64(b);
          v = (a[63] ^ b[63]) ? -q : q;
        end
      end
      CMD_EQ:   v = 64'(a == b);
      CMD_NE:   v = 64'(a != b);
      CMD_LT:   v = 64'($signed(a) < $signed(b));
      CMD_LE:   v = 64'($signed(a) <= $signed(b));
      CMD_GT:   v = 64'($signed(a) > $signed(b));
      CMD_GE:   v = 64'($signed(a) >= $signed(b));
      CMD_OR:   v = a | b;
      CMD_AND:  v = a & b;
      CMD_XOR:  v = a ^ b;
      CMD_LOR:  v = 64'((a != 0) || (b != 0));
      CMD_LAND: v = 64'((a != 0) && (b != 0));
      CMD_LOG2: begin
        v = '1;
        if (a == MinVal) v = 64'd63;
        else begin
          q = abs64(a);
          for (int i = 0; i < 63; i++) if (q[i]) v = 64'(i);
        end
      end
      CMD_POW2: begin
        if (a <= 64'd63) v = 64'd1 << a[5:0];
        else st = ST_OVF;
      end
      default: st = ST_OVF;
    endcase
    if (st != ST_OK) v = '0;
    compute_alu.value = v;
    compute_alu.status = st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      errors_o <= 0;
      results_o <= 0;
      alu_results_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) alu_results_q.push_back(compute_alu(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (alu_results_q.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   out_data_i.value, out_data_i.status);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = alu_results_q.pop_front();
          if (exp_r.value !== out_data_i.value || exp_r.status !== out_data_i.status) begin
            $display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
                     $time, exp_r.value, exp_r.status, out_data_i.value, out_data_i.status);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = alu_results_q.size();
endmodule

/* tb/sv/tb_top.sv */
// Testbench top for checked_int64_alu.
// Drives directed and random transactions with random idling; alu_checker does the checks.
// Depends on cai_pkg, checked_int64_alu and alu_checker.
module tb_top;
  import cai_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1600;
  localparam int IdleLimit = 2000;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_data_i = '0;
  logic in_stall_o, out_valid_o;
  out_t out_data_o;
  int   errors, pending, results;
  int   idle_cycles = 0;
  bit   calm = 1'b0;
  in_t  stim_q[$];

  always #10 clk_i = ~clk_i;

  checked_int64_alu dut (.*);

  alu_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MinVal;
      1: return MaxVal;
      2: return 64'($urandom_range(0, 3)) - 64'd1;
      3: return 64'($signed($urandom_range(0, 130)) - 65);
      4: return {{32{1'b0}}, $urandom()} ^ {64{$urandom_range(0, 1) == 1}};
      5: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic in_t make_txn(logic [4:0] c, logic [63:0] a, logic [63:0] b);
    make_txn.command = c;
    make_txn.operand_a = a;
    make_txn.operand_b = b;
  endfunction

  // Output stall bursts
  always @(posedge clk_i) begin
    if (!calm && $urandom_range(0, 19) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
  end

  // Watchdog on accepted transactions
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_t t;
    cmd_e c;
    for (int i = 0; i < 17; i++) begin
      c = cmd_e'(i);
      stim_q.push_back(make_txn(c, MaxVal, 64'd1));
      stim_q.push_back(make_txn(c, MinVal, '1));
    end
    stim_q.push_back(make_txn(CMD_DIV, 64'd7, 64'd0));
    stim_q.push_back(make_txn(CMD_DIV, -64'sd7, 64'd2));
    stim_q.push_back(make_txn(CMD_MUL, 64'h1_0000_0000, 64'h8000_0000));
    stim_q.push_back(make_txn(CMD_MUL, 64'h1_0000_0000, -64'sh8000_0000));
    stim_q.push_back(make_txn(CMD_LOG2, 64'd0, 64'd0));
    stim_q.push_back(make_txn(CMD_POW2, 64'd63, 64'd0));
    stim_q.push_back(make_txn(CMD_POW2, 64'd64, 64'd0));
    stim_q.push_back(make_txn(5'd31, 64'd1, 64'd1));
    for (int i = 0; i < NumRandom; i++) begin
      t.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
      t.operand_a = pick_operand();
      t.operand_b = pick_operand();
      if (t.command == CMD_POW2 && $urandom_range(0, 1)) t.operand_a = 64'($urandom_range(0, 70));
      stim_q.push_back(t);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i > stim_q.size() - 200) calm = 1'b1;
      if (!calm && $urandom_range(0, 15) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i <= stim_q[i];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Covered %0d transactions over all commands, unknown codes and edge operands;",
             stim_q.size());
    $display("%0d results checked with random stalls on both channels.", results);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
